// ----- hdl/srs_pkg.sv -----
// Shared types, constants and generator functions for the seeded array shuffler.
// Used by the front end, back end, generator and top level; depends on nothing else.
`default_nettype none
package srs_pkg;

  // MT19937-64 state geometry.
  localparam int unsigned GEN_N = 312;
  localparam logic [8:0] GEN_LAST  = 9'd311;
  localparam logic [8:0] GEN_M     = 9'd156;
  localparam logic [8:0] GEN_SPLIT = 9'd156;

  localparam logic [63:0] GEN_MATRIX       = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] GEN_UPPER        = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] GEN_LOWER        = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] GEN_DEFAULT_SEED = 64'd5489;
  localparam logic [63:0] GEN_SEED_MULT    = 64'h5851_F42D_4C95_7F2D;

  // Shuffle mode codes; the fourth code behaves like off.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CONT   = 2'd1;
  localparam logic [1:0] MODE_RESEED = 2'd2;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } srs_reg_t;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_LOAD_LAST = 2'd1,
    CMD_READ      = 2'd2
  } srs_kind_t;

  typedef struct packed {
    srs_kind_t   kind;
    logic [63:0] element;
  } srs_cmd_t;

  typedef struct packed {
    logic        seed;
    logic        draw;
    logic [63:0] seed_word;
  } gen_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_stat_t;

  function automatic logic [63:0] gen_twist(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [63:0] far);
    logic [63:0] x;
    begin
      x = (hi & GEN_UPPER) | (lo & GEN_LOWER);
      gen_twist = far ^ (x >> 1) ^ (x[0] ? GEN_MATRIX : 64'd0);
    end
  endfunction

  function automatic logic [63:0] gen_temper(input logic [63:0] y);
    logic [63:0] x;
    begin
      x = y;
      x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
      x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
      x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
      x = x ^ (x >> 43);
      gen_temper = x;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/srs_front.sv -----
// Command front end: classifies incoming words and queues them in a two-entry FIFO.
// Depends on srs_pkg.
`default_nettype none
module srs_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             req_type,
  input  wire logic [63:0]      element_in,
  input  wire logic             last_in,
  output logic                  cmd_valid,
  output srs_pkg::srs_cmd_t     cmd,
  input  wire logic             cmd_pop
);

  srs_pkg::srs_cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  srs_pkg::srs_cmd_t in_cmd;

  assign busy      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push      = start && !busy;

  always_comb begin
    in_cmd.element = element_in;
    if (req_type) begin
      in_cmd.kind = srs_pkg::CMD_READ;
    end else if (last_in) begin
      in_cmd.kind = srs_pkg::CMD_LOAD_LAST;
    end else begin
      in_cmd.kind = srs_pkg::CMD_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= in_cmd;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srs_gen.sv -----
// MT19937-64 generator: seeding pass over the word memory and one tempered draw per request.
// Depends on srs_pkg.
`default_nettype none
module srs_gen (
  input  wire logic        clk,
  input  wire logic        rst,
  input  srs_pkg::gen_req_t req,
  output srs_pkg::gen_stat_t stat,
  output logic [63:0]      word
);

  typedef enum logic [6:0] {
    G_IDLE = 7'b0000001,
    G_INIT = 7'b0000010,
    G_SEED = 7'b0000100,
    G_RD1  = 7'b0001000,
    G_RD2  = 7'b0010000,
    G_TW   = 7'b0100000,
    G_TEMP = 7'b1000000
  } gen_state_t;

  gen_state_t  state;
  logic [63:0] words [srs_pkg::GEN_N];
  logic [63:0] rd_a;
  logic [63:0] rd_b;
  logic [63:0] seed_reg;
  logic [63:0] prev;
  logic [8:0]  sidx;
  logic [1:0]  phase;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [8:0]  gi;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] y;
  logic        done;

  logic [63:0] x;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul;
  logic [63:0] seed_sum;
  logic [63:0] twisted;
  logic [8:0]  gi_next;
  logic [8:0]  gi_far;
  logic        we;
  logic [8:0]  wa;
  logic [63:0] wd;
  logic [8:0]  ra;

  assign stat.busy = (state != G_IDLE);
  assign stat.done = done;

  // Low 64 bits of the seeding product, built from three 32x32 partial products.
  assign x        = prev ^ (prev >> 62);
  assign mul_a    = (phase == 2'd2) ? x[63:32] : x[31:0];
  assign mul_b    = (phase == 2'd1) ? srs_pkg::GEN_SEED_MULT[63:32]
                                    : srs_pkg::GEN_SEED_MULT[31:0];
  assign mul      = {32'd0, mul_a} * {32'd0, mul_b};
  assign seed_sum = acc + {prod[31:0], 32'd0} + {55'd0, sidx};

  assign twisted  = srs_pkg::gen_twist(hi, lo, rd_a);
  assign gi_next  = (gi == srs_pkg::GEN_LAST) ? 9'd0 : gi + 9'd1;
  assign gi_far   = (gi >= srs_pkg::GEN_SPLIT) ? gi - srs_pkg::GEN_SPLIT : gi + srs_pkg::GEN_M;
  assign ra       = (state == G_RD1) ? gi : gi_far;

  always_comb begin
    we = 1'b0;
    wa = sidx;
    wd = seed_sum;
    unique case (state)
      G_INIT: begin
        we = 1'b1;
        wa = 9'd0;
        wd = seed_reg;
      end
      G_SEED: begin
        we = (phase == 2'd3);
      end
      G_TW: begin
        we = 1'b1;
        wa = gi;
        wd = twisted;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      words[wa] <= wd;
    end
    rd_a <= words[ra];
    rd_b <= words[gi_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= G_INIT;
      seed_reg <= srs_pkg::GEN_DEFAULT_SEED;
      gi       <= 9'd0;
      sidx     <= 9'd1;
      phase    <= 2'd0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (req.seed) begin
            seed_reg <= req.seed_word;
            state    <= G_INIT;
          end else if (req.draw) begin
            state <= G_RD1;
          end
        end
        G_INIT: begin
          prev  <= seed_reg;
          sidx  <= 9'd1;
          phase <= 2'd0;
          state <= G_SEED;
        end
        G_SEED: begin
          phase <= phase + 2'd1;
          prod  <= mul;
          case (phase)
            2'd1: acc <= prod;
            2'd2: acc <= acc + {prod[31:0], 32'd0};
            2'd3: begin
              prev <= seed_sum;
              sidx <= sidx + 9'd1;
              if (sidx == srs_pkg::GEN_LAST) begin
                gi    <= 9'd0;
                state <= G_IDLE;
              end
            end
            default: acc <= acc;
          endcase
        end
        G_RD1: begin
          state <= G_RD2;
        end
        G_RD2: begin
          hi    <= rd_a;
          lo    <= rd_b;
          state <= G_TW;
        end
        G_TW: begin
          y     <= twisted;
          state <= G_TEMP;
        end
        G_TEMP: begin
          word  <= srs_pkg::gen_temper(y);
          done  <= 1'b1;
          gi    <= gi_next;
          state <= G_IDLE;
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srs_mod.sv -----
// Bit-serial 64-bit remainder unit: one dividend bit per cycle against a narrow divisor.
// Depends on nothing outside this file.
`default_nettype none
module srs_mod #(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [63:0]                    dividend,
  input  wire logic [$clog2(MAX_ELEMS+1)-1:0] divisor,
  output logic                                done,
  output logic [$clog2(MAX_ELEMS)-1:0]        rem
);

  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMS);

  logic          busy;
  logic [63:0]   q;
  logic [CW-1:0] r;
  logic [CW-1:0] div;
  logic [5:0]    cnt;
  logic [CW:0]   t;
  logic [CW:0]   diff;
  logic          ge;

  assign t    = {r, q[63]};
  assign diff = t - {1'b0, div};
  assign ge   = (t >= {1'b0, div});
  assign rem  = r[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        div  <= divisor;
        r    <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        r   <= ge ? diff[CW-1:0] : t[CW-1:0];
        q   <= {q[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srs_back.sv -----
// Execution back end: element memory, run bookkeeping, reads and the Fisher-Yates sequencer.
// Depends on srs_pkg and srs_mod.
`default_nettype none
module srs_back #(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  srs_pkg::srs_cmd_t cmd,
  output logic              cmd_pop,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_data,
  output srs_pkg::gen_req_t gen_req,
  input  srs_pkg::gen_stat_t gen_stat,
  input  wire logic [63:0]  gen_word,
  output logic              idle,
  output logic              strobe,
  output logic [63:0]       element_out,
  output logic              last_out
);

  localparam int unsigned CW = $clog2(MAX_ELEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [7:0] {
    B_IDLE    = 8'b00000001,
    B_READ    = 8'b00000010,
    B_SEED    = 8'b00000100,
    B_DRAW    = 8'b00001000,
    B_DWAIT   = 8'b00010000,
    B_MOD     = 8'b00100000,
    B_SWAP_RD = 8'b01000000,
    B_SWAP_W  = 8'b10000000
  } back_state_t;

  back_state_t   state;
  logic [1:0]    mode;
  logic [63:0]   seed_value;
  logic [CW-1:0] count;
  logic [CW-1:0] rp;
  logic          run_ready;
  logic [CW-1:0] pos;
  logic [AW-1:0] pick;
  logic          swap_second;
  logic [63:0]   mem [MAX_ELEMS];
  logic [63:0]   rd_a;
  logic [63:0]   rd_b;

  logic          go;
  logic [CW-1:0] eff;
  logic          ld_ok;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] pos_m1;
  logic          we;
  logic [AW-1:0] wa;
  logic [63:0]   wd;
  logic [AW-1:0] ra;
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic          is_reg_seed;
  logic          reseed_run;

  assign go          = (state == B_IDLE) && cmd_valid && !gen_stat.busy;
  assign cmd_pop     = go;
  assign idle        = (state == B_IDLE) && !gen_stat.busy;
  assign eff         = run_ready ? '0 : count;
  assign ld_ok       = (eff < MAXC);
  assign cnt_new     = ld_ok ? eff + ONE : eff;
  assign pos_m1      = pos - ONE;
  assign is_reg_seed = (srs_pkg::srs_reg_t'(cfg_index) == srs_pkg::REG_SEED);
  assign reseed_run  = go && (cmd.kind == srs_pkg::CMD_LOAD_LAST) && (mode == srs_pkg::MODE_RESEED);

  assign strobe      = (state == B_READ);
  assign element_out = rd_a;
  assign mod_start   = (state == B_DWAIT) && gen_stat.done;

  always_comb begin
    gen_req.seed      = (cfg_we && is_reg_seed) || reseed_run;
    gen_req.seed_word = (cfg_we && is_reg_seed) ? cfg_data : {32'd0, seed_value[31:0]};
    gen_req.draw      = (state == B_DRAW);
  end

  always_comb begin
    we = 1'b0;
    wa = eff[AW-1:0];
    wd = cmd.element;
    if (go && (cmd.kind != srs_pkg::CMD_READ)) begin
      we = ld_ok;
    end else if (state == B_SWAP_W) begin
      we = 1'b1;
      if (swap_second) begin
        wa = pos_m1[AW-1:0];
        wd = rd_b;
      end else begin
        wa = pick;
        wd = rd_a;
      end
    end
  end

  assign ra = (state == B_IDLE) ? rp[AW-1:0] : pos_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (!(state == B_SWAP_W)) begin
      rd_a <= mem[ra];
      rd_b <= mem[pick];
    end
  end

  srs_mod #(.MAX_ELEMS(MAX_ELEMS)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (gen_word),
    .divisor  (pos),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      mode        <= srs_pkg::MODE_OFF;
      seed_value  <= 64'd1;
      count       <= '0;
      rp          <= '0;
      run_ready   <= 1'b0;
      swap_second <= 1'b0;
      pick        <= '0;
    end else begin
      if (cfg_we) begin
        if (is_reg_seed) begin
          seed_value <= cfg_data;
        end else begin
          mode <= cfg_data[1:0];
        end
      end
      unique case (state)
        B_IDLE: begin
          if (go) begin
            case (cmd.kind)
              srs_pkg::CMD_LOAD: begin
                count     <= cnt_new;
                rp        <= '0;
                run_ready <= 1'b0;
              end
              srs_pkg::CMD_LOAD_LAST: begin
                count     <= cnt_new;
                rp        <= '0;
                run_ready <= 1'b1;
                pos       <= cnt_new;
                if (mode == srs_pkg::MODE_RESEED) begin
                  state <= B_SEED;
                end else if ((mode == srs_pkg::MODE_CONT) && (cnt_new > ONE)) begin
                  state <= B_DRAW;
                end
              end
              srs_pkg::CMD_READ: begin
                if (run_ready && (rp < count)) begin
                  last_out <= ((rp + ONE) == count);
                  rp       <= rp + ONE;
                  state    <= B_READ;
                end
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_READ: begin
          state <= B_IDLE;
        end
        B_SEED: begin
          if (!gen_stat.busy) begin
            state <= (count > ONE) ? B_DRAW : B_IDLE;
          end
        end
        B_DRAW: begin
          state <= B_DWAIT;
        end
        B_DWAIT: begin
          if (gen_stat.done) begin
            state <= B_MOD;
          end
        end
        B_MOD: begin
          if (mod_done) begin
            pick  <= mod_rem;
            state <= B_SWAP_RD;
          end
        end
        B_SWAP_RD: begin
          swap_second <= 1'b0;
          state       <= B_SWAP_W;
        end
        B_SWAP_W: begin
          swap_second <= 1'b1;
          if (swap_second) begin
            pos   <= pos_m1;
            state <= (pos == ONE) ? B_IDLE : B_DRAW;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/seeded_array_shuffler_core.sv -----
// Top level of the seeded array shuffler: front queue, execution back end, generator.
// Depends on srs_pkg, srs_front, srs_back (with srs_mod) and srs_gen.
//
// The block collects a run of 64-bit elements, shuffles it with a Fisher-Yates walk
// driven by an MT19937-64 generator, and returns the elements one per read word.
// A word is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Results appear for exactly one cycle with strobe
// high and cannot be held off, so the receiver must take them as they come. A load
// passes through the queue and is written when the back end dequeues it; a read is
// dequeued in the idle state and its element, registered from memory, is shown with
// strobe in the read state. Closing a run in a shuffling mode walks the positions
// down from the top, each through the generator draw and its handoff, the bit-serial
// remainder unit and the swap through the single write port of the element memory.
// After reset, after a seed write and when each run closes in reseed mode, the
// generator seeds its 312-word memory one word at a time through a shared 32x32
// multiplier; queued words wait, and the configuration port is not ready.
// Configuration writes are accepted only when the block is idle with an empty queue.
`default_nettype none
module seeded_array_shuffler_core #(
  parameter int unsigned MAX_ELEMS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [63:0] element_in,
  input  wire logic        last_in,
  output logic             strobe,
  output logic [63:0]      element_out,
  output logic             last_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  // Command words queued between the front end and the executing back end.
  logic               cmd_valid;
  srs_pkg::srs_cmd_t  cmd;
  logic               cmd_pop;

  // Generator request and status.
  srs_pkg::gen_req_t  gen_req;
  srs_pkg::gen_stat_t gen_stat;
  logic [63:0]        gen_word;

  logic back_idle;
  logic cfg_we;

  // Registers are written only with nothing queued and nothing executing.
  assign cfg_ready = back_idle && !cmd_valid;
  assign cfg_we    = cfg_valid && cfg_ready;

  srs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .element_in (element_in),
    .last_in    (last_in),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  srs_back #(.MAX_ELEMS(MAX_ELEMS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gen_req     (gen_req),
    .gen_stat    (gen_stat),
    .gen_word    (gen_word),
    .idle        (back_idle),
    .strobe      (strobe),
    .element_out (element_out),
    .last_out    (last_out)
  );

  // The generator runs on its own so the back end only waits on the draw it needs.
  srs_gen u_gen (
    .clk  (clk),
    .rst  (rst),
    .req  (gen_req),
    .stat (gen_stat),
    .word (gen_word)
  );

endmodule
`default_nettype wire

// ----- hdl/srs_checker.sv -----
// Port-level checker for the seeded array shuffler, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module srs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic strobe,
  input wire logic cfg_ready
);

  // Every read word needs a dequeue cycle, so strobes never come back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("strobe held for two cycles");

  // Reset empties the queue and drops any pending result.
  a_reset_clean: assert property (@(posedge clk) rst |=> (!strobe && !busy))
    else $error("result or busy after reset");

  // Configuration is only taken with an empty queue; this checks that the queue is not full.
  a_cfg_empty: assert property (@(posedge clk) disable iff (rst) cfg_ready |-> !busy)
    else $error("cfg_ready while queue full");

endmodule

bind seeded_array_shuffler_core srs_checker u_srs_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .cfg_ready (cfg_ready)
);
`default_nettype wire
